### rtl/pie_pkg.sv
package pie_pkg;

    // Table size and derived widths.
    localparam int CAPACITY   = 64;
    localparam int WORD_W     = 64;
    localparam int CNT_W      = 7;
    localparam int GROUP_SIZE = 8;
    localparam int GROUP_CNT  = CAPACITY / GROUP_SIZE;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_WRITE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_GATHER
    } state_t;

    // Command broadcast from the control logic to every cell.
    typedef struct packed {
        logic              apply;
        cmd_t              cmd;
        logic [CNT_W-1:0]  pos;
        logic [WORD_W-1:0] value;
    } cell_bus_t;

endpackage

### rtl/positional_insert_erase_array_top.sv
// Positional insert/erase array: an ordered table of 64-bit words with a live count.
// Input channel (in_valid / in_stall) carries one command per transfer: cmd selects
// insert, erase, read or write, position picks the entry and value holds the word
// to insert or write. Output channel (out_valid / out_stall) returns one result
// per command: read_value (zero unless a good read), count after the command and
// status (ok, position out of range, table full).
// Each command passes through the transfer, an execute step in which every cell
// of the chain shifts, loads or holds at once, and a gather step that finishes the
// two-level OR tree selecting the read word. The input channel stalls while a
// command is in flight, so a new command is taken only after the previous one
// leaves the gather step. The output register lets the next command be taken
// while the previous result still waits; a stalled result holds, and the block then
// waits in its last step until the output register frees up.
// Reset clears the count and the handshake state; entry contents are left
// undefined and are never returned before they are written.
module positional_insert_erase_array_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          cmd,
    input  logic [pie_pkg::CNT_W-1:0]           position,
    input  logic [pie_pkg::WORD_W-1:0]          value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [pie_pkg::WORD_W-1:0]          read_value,
    output logic [pie_pkg::CNT_W-1:0]           count,
    output logic [1:0]                          status
);
    import pie_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Command captured on the input transfer.
    cmd_t              cmd_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [WORD_W-1:0] value_reg;

    logic [CNT_W-1:0]  live_count_reg;
    logic [CNT_W-1:0]  live_count_next;

    // Outcome of the execute step, kept for the gather step.
    status_t           res_status_reg;
    logic              res_read_reg;

    logic              out_valid_reg;
    logic [WORD_W-1:0] read_value_reg;
    logic [CNT_W-1:0]  count_reg;
    status_t           status_reg;

    logic              in_accept;
    logic              exec_step;
    logic              out_load;
    status_t           exec_status;
    cell_bus_t         bus;

    logic [CAPACITY-1:0][WORD_W-1:0] entry_words;
    logic [CAPACITY-1:0][WORD_W-1:0] sel_words;
    logic [WORD_W-1:0]               gathered_word;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign exec_step = (state_reg == S_EXEC);
    assign out_load  = (state_reg == S_GATHER) && (!out_valid_reg || !out_stall);

    // Range and capacity checks against the count before the command.
    always_comb
    begin
        exec_status = ST_OK;
        case (cmd_reg)
            CMD_INSERT:
            begin
                if (pos_reg > live_count_reg)
                    exec_status = ST_RANGE;
                else if (live_count_reg >= CNT_W'(CAPACITY))
                    exec_status = ST_FULL;
            end
            default:
            begin
                if (pos_reg >= live_count_reg)
                    exec_status = ST_RANGE;
            end
        endcase
    end

    always_comb
    begin
        live_count_next = live_count_reg;
        if (exec_step && (exec_status == ST_OK))
        begin
            case (cmd_reg)
                CMD_INSERT: live_count_next = live_count_reg + 1'b1;
                CMD_ERASE:  live_count_next = live_count_reg - 1'b1;
                default:    live_count_next = live_count_reg;
            endcase
        end
    end

    assign bus.apply = exec_step && (exec_status == ST_OK);
    assign bus.cmd   = cmd_reg;
    assign bus.pos   = pos_reg;
    assign bus.value = value_reg;

    // The chain of cells: each one sees both neighbors' words.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [WORD_W-1:0] left_word;
        logic [WORD_W-1:0] right_word;

        if (i == 0)
        begin : g_first
            assign left_word = '0;
        end
        else
        begin : g_mid_l
            assign left_word = entry_words[i - 1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_word = '0;
        end
        else
        begin : g_mid_r
            assign right_word = entry_words[i + 1];
        end

        pie_cell u_cell (
            .clk        (clk),
            .bus        (bus),
            .index      (CNT_W'(i)),
            .left_word  (left_word),
            .right_word (right_word),
            .entry      (entry_words[i]),
            .sel_word   (sel_words[i])
        );
    end

    pie_gather u_gather (
        .clk     (clk),
        .capture (exec_step),
        .words   (sel_words),
        .word    (gathered_word)
    );

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_GATHER;
            end
            S_GATHER:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            live_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            live_count_reg <= live_count_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg   <= cmd_t'(cmd);
            pos_reg   <= position;
            value_reg <= value;
        end
        if (exec_step)
        begin
            res_status_reg <= exec_status;
            res_read_reg   <= (cmd_reg == CMD_READ) && (exec_status == ST_OK);
        end
        if (out_load)
        begin
            read_value_reg <= res_read_reg ? gathered_word : '0;
            count_reg      <= live_count_reg;
            status_reg     <= res_status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign count      = count_reg;
    assign status     = status_reg;

endmodule

### rtl/pie_cell.sv
module pie_cell (
    input  logic                         clk,
    input  pie_pkg::cell_bus_t           bus,
    input  logic [pie_pkg::CNT_W-1:0]    index,
    input  logic [pie_pkg::WORD_W-1:0]   left_word,
    input  logic [pie_pkg::WORD_W-1:0]   right_word,
    output logic [pie_pkg::WORD_W-1:0]   entry,
    output logic [pie_pkg::WORD_W-1:0]   sel_word
);
    import pie_pkg::*;

    logic [WORD_W-1:0] entry_reg;
    logic [WORD_W-1:0] entry_next;
    logic              hit;
    logic              above;

    assign hit   = (index == bus.pos);
    assign above = (index > bus.pos);

    // Each cell keeps its own value or takes the command's value, its lower neighbor's or its upper neighbor's.
    always_comb
    begin
        entry_next = entry_reg;
        if (bus.apply)
        begin
            case (bus.cmd)
                CMD_INSERT:
                begin
                    if (hit)
                        entry_next = bus.value;
                    else if (above)
                        entry_next = left_word;
                end
                CMD_ERASE:
                begin
                    if (hit || above)
                        entry_next = right_word;
                end
                CMD_WRITE:
                begin
                    if (hit)
                        entry_next = bus.value;
                end
                default:
                begin
                    entry_next = entry_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry    = entry_reg;
    assign sel_word = hit ? entry_reg : '0;

endmodule

### rtl/pie_gather.sv
module pie_gather (
    input  logic                                          clk,
    input  logic                                          capture,
    input  logic [pie_pkg::CAPACITY-1:0][pie_pkg::WORD_W-1:0] words,
    output logic [pie_pkg::WORD_W-1:0]                    word
);
    import pie_pkg::*;

    logic [GROUP_CNT-1:0][WORD_W-1:0] group_reg;
    logic [GROUP_CNT-1:0][WORD_W-1:0] group_next;

    // First level: OR each group of cells; at most one cell is selected.
    always_comb
    begin
        for (int g = 0; g < GROUP_CNT; g++)
        begin
            group_next[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++)
                group_next[g] = group_next[g] | words[g * GROUP_SIZE + k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
            group_reg <= group_next;
    end

    // Second level combines the registered group results.
    always_comb
    begin
        word = '0;
        for (int g = 0; g < GROUP_CNT; g++)
            word = word | group_reg[g];
    end

endmodule
